[hw/rtl/bmp24_stream_from_rgb565_top_assert.svh]
// Assertion macros shared by the BMP stream RTL.
`ifndef BMP24_STREAM_FROM_RGB565_TOP_ASSERT_SVH
`define BMP24_STREAM_FROM_RGB565_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bmp24_pkg.sv]
// Package: widths, BMP header layout and register indexes for the BMP byte stream.
`timescale 1ns / 1ps
`default_nettype none

package bmp24_pkg;

	// widths
	localparam int SIDE_W = 13;  // width / height register and counters
	localparam int ROW_W  = 15;  // bytes per padded row
	localparam int SIZE_W = 32;  // size fields of the header
	localparam int IDX_W  = 6;   // byte index within one pixel's run

	// register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// header layout
	localparam logic [IDX_W-1:0] HDR_BYTES    = 6'd54;
	localparam logic [IDX_W-1:0] OFS_MAGIC_B  = 6'd0;
	localparam logic [IDX_W-1:0] OFS_MAGIC_M  = 6'd1;
	localparam logic [IDX_W-1:0] OFS_FILE_SZ  = 6'd2;
	localparam logic [IDX_W-1:0] OFS_DATA_OFS = 6'd10;
	localparam logic [IDX_W-1:0] OFS_INFO_SZ  = 6'd14;
	localparam logic [IDX_W-1:0] OFS_WIDTH    = 6'd18;
	localparam logic [IDX_W-1:0] OFS_HEIGHT   = 6'd22;
	localparam logic [IDX_W-1:0] OFS_PLANES   = 6'd26;
	localparam logic [IDX_W-1:0] OFS_BPP      = 6'd28;
	localparam logic [IDX_W-1:0] OFS_IMG_SZ   = 6'd34;

	// pixel bytes follow the header: blue, green, red, then row padding
	localparam logic [IDX_W-1:0] IDX_BLUE  = 6'd54;
	localparam logic [IDX_W-1:0] IDX_GREEN = 6'd55;
	localparam logic [IDX_W-1:0] IDX_RED   = 6'd56;

	// header byte values
	localparam logic [7:0] MAGIC_B   = 8'h42;
	localparam logic [7:0] MAGIC_M   = 8'h4D;
	localparam logic [7:0] DATA_OFS  = 8'd54;
	localparam logic [7:0] INFO_SZ   = 8'd40;
	localparam logic [7:0] PLANES    = 8'd1;
	localparam logic [7:0] BPP       = 8'd24;

endpackage

`default_nettype wire

[hw/rtl/bmp24_stream_from_rgb565_top.sv]
// Top level: RGB565 pixel stream in, 24-bit BMP file byte stream out.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------
//  input    | in_valid / in_ready      | pixel[15:0]
//  output   | out_valid / out_ready    | out_byte[7:0], run_end, frame_end
//  config   | cfg_we (no wait)         | cfg_index, cfg_data[12:0]
//
// Output runs at one byte per cycle unless out_ready stalls: 3 per pixel,
// plus 54 header bytes on a frame's first pixel, 0-3 padding at a row end.
// The single byte output register sets the rate; the next pixel is taken on
// the cycle its predecessor's last beat enters that register.
// Header sizes come from a registered 15x13 multiply of the snapshot.
// Reset restores width 320, height 240 and starts a new frame.
`timescale 1ns / 1ps
`default_nettype none

`include "bmp24_stream_from_rgb565_top_assert.svh"

module bmp24_stream_from_rgb565_top #(
	parameter int MAX_SIDE = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] pixel,
	// byte output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             run_end,
	output logic             frame_end,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam int SW = bmp24_pkg::SIDE_W;
	localparam int RW = bmp24_pkg::ROW_W;
	localparam int ZW = bmp24_pkg::SIZE_W;
	localparam int IW = bmp24_pkg::IDX_W;

	// configuration registers
	logic [SW-1:0] width_q, height_q;

	// frame position
	logic [SW-1:0] col_q, row_q;
	logic          hdr_sent_q;

	// item being serialized
	logic          busy_s1;
	logic [IW-1:0] idx_s1, last_s1;
	logic          fend_s1;
	logic [15:0]   pixel_s1;
	logic [SW-1:0] w_s1, h_s1;
	logic [RW-1:0] row_size_s1;

	// image size, registered from the snapshot
	logic [ZW-1:0] size_s2;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q, frame_end_q;

	logic          accept, adv, at_last;
	logic [SW-1:0] w_cl, h_cl;
	logic [SW:0]   col_inc, row_inc;
	logic          row_done, frame_done;
	logic [1:0]    pad;
	logic [RW-1:0] row_size;
	logic [ZW-1:0] file_size;
	logic [1:0]    bsel;
	logic [7:0]    byte_nx;
	logic [4:0]    b5, r5;
	logic [5:0]    g6;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(320);
			height_q <= SW'(240);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmp24_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bmp24_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sides to 1..MAX_SIDE
	always_comb begin
		w_cl = width_q;
		if (width_q == '0)
			w_cl = SW'(1);
		else if (32'(width_q) > MAX_SIDE)
			w_cl = SW'(MAX_SIDE);
		h_cl = height_q;
		if (height_q == '0)
			h_cl = SW'(1);
		else if (32'(height_q) > MAX_SIDE)
			h_cl = SW'(MAX_SIDE);
	end

	// handshake and sequencing
	assign adv      = busy_s1 && (!out_valid_q || out_ready);
	assign at_last  = idx_s1 == last_s1;
	assign in_ready = !busy_s1 || (adv && at_last);
	assign accept   = in_valid && in_ready;

	// position update for the accepted pixel
	always_comb begin
		col_inc    = {1'b0, col_q} + (SW+1)'(1);
		row_inc    = {1'b0, row_q} + (SW+1)'(1);
		row_done   = col_inc >= {1'b0, w_cl};
		frame_done = row_done && (row_inc >= {1'b0, h_cl});
		pad        = row_done ? w_cl[1:0] : 2'd0;
		row_size   = ((RW'(w_cl) * RW'(3)) + RW'(3)) & ~RW'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			hdr_sent_q <= 1'b0;
		end else if (accept) begin
			if (row_done) begin
				col_q <= '0;
				if (frame_done) begin
					row_q      <= '0;
					hdr_sent_q <= 1'b0;
				end else begin
					row_q      <= row_inc[SW-1:0];
					hdr_sent_q <= 1'b1;
				end
			end else begin
				col_q      <= col_inc[SW-1:0];
				hdr_sent_q <= 1'b1;
			end
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= '0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
			idx_s1  <= hdr_sent_q ? bmp24_pkg::HDR_BYTES : '0;
		end else if (adv) begin
			if (at_last)
				busy_s1 <= 1'b0;
			idx_s1 <= idx_s1 + IW'(1);
		end
	end

	// item payload snapshot
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel;
			last_s1     <= bmp24_pkg::IDX_RED + IW'(pad);
			fend_s1     <= frame_done;
			w_s1        <= w_cl;
			h_s1        <= h_cl;
			row_size_s1 <= row_size;
		end
		size_s2 <= ZW'(row_size_s1) * ZW'(h_s1);
	end

	// byte selection
	assign file_size = size_s2 + ZW'(bmp24_pkg::HDR_BYTES);
	assign b5 = pixel_s1[4:0];
	assign g6 = pixel_s1[10:5];
	assign r5 = pixel_s1[15:11];

	always_comb begin
		bsel    = idx_s1[1:0] - bmp24_pkg::OFS_FILE_SZ[1:0];
		byte_nx = 8'h00;
		if (idx_s1 == bmp24_pkg::OFS_MAGIC_B)
			byte_nx = bmp24_pkg::MAGIC_B;
		else if (idx_s1 == bmp24_pkg::OFS_MAGIC_M)
			byte_nx = bmp24_pkg::MAGIC_M;
		else if (idx_s1 >= bmp24_pkg::OFS_FILE_SZ &&
				idx_s1 < bmp24_pkg::OFS_FILE_SZ + IW'(4))
			byte_nx = file_size[8*bsel +: 8];
		else if (idx_s1 == bmp24_pkg::OFS_DATA_OFS)
			byte_nx = bmp24_pkg::DATA_OFS;
		else if (idx_s1 == bmp24_pkg::OFS_INFO_SZ)
			byte_nx = bmp24_pkg::INFO_SZ;
		else if (idx_s1 == bmp24_pkg::OFS_WIDTH)
			byte_nx = w_s1[7:0];
		else if (idx_s1 == bmp24_pkg::OFS_WIDTH + IW'(1))
			byte_nx = 8'(w_s1[SW-1:8]);
		else if (idx_s1 == bmp24_pkg::OFS_HEIGHT)
			byte_nx = h_s1[7:0];
		else if (idx_s1 == bmp24_pkg::OFS_HEIGHT + IW'(1))
			byte_nx = 8'(h_s1[SW-1:8]);
		else if (idx_s1 == bmp24_pkg::OFS_PLANES)
			byte_nx = bmp24_pkg::PLANES;
		else if (idx_s1 == bmp24_pkg::OFS_BPP)
			byte_nx = bmp24_pkg::BPP;
		else if (idx_s1 >= bmp24_pkg::OFS_IMG_SZ &&
				idx_s1 < bmp24_pkg::OFS_IMG_SZ + IW'(4))
			byte_nx = size_s2[8*bsel +: 8];
		else if (idx_s1 == bmp24_pkg::IDX_BLUE)
			byte_nx = {b5, b5[4:2]};
		else if (idx_s1 == bmp24_pkg::IDX_GREEN)
			byte_nx = {g6, g6[5:4]};
		else if (idx_s1 == bmp24_pkg::IDX_RED)
			byte_nx = {r5, r5[4:2]};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= byte_nx;
			run_end_q   <= at_last;
			frame_end_q <= at_last && fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

	// checks
	`BMP_ASSERT_NOW(a_fend_on_run_end, out_valid_q && frame_end_q, run_end_q,
		"frame end flagged on a beat that does not end its pixel")
	`BMP_ASSERT_NOW(a_idx_in_range, busy_s1, idx_s1 <= last_s1,
		"byte index ran past the last byte of the pixel")
	`BMP_ASSERT_NEXT(a_start_idx, accept,
		(($past(hdr_sent_q) && idx_s1 == bmp24_pkg::HDR_BYTES) ||
		(!$past(hdr_sent_q) && idx_s1 == '0)),
		"pixel started at the wrong byte index")

endmodule

`default_nettype wire

[sim/bmp24_stream_from_rgb565_top_tb.sv]
// Self-checking testbench for the RGB565 to 24-bit BMP byte stream block.
`timescale 1ns / 1ps

module bmp24_stream_from_rgb565_top_tb;

	localparam int SIDE_MAX    = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_MODE = 34;

	// one byte of the file with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       pixel_last;
		logic       file_last;
	} bmp_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] pixel = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        run_end;
	logic        frame_end;
	logic        cfg_we = 1'b0;
	logic        cfg_index = bmp24_pkg::REG_IMAGE_WIDTH;
	logic [12:0] cfg_data = 13'd0;

	// stimulus and expected bytes
	logic [15:0] pixels_pending[$];
	bmp_byte_t   bytes_due[$];
	int          pixels_in_flight = 0;
	bit          pixel_taken = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	// predictor state: raw registers and frame position
	logic [12:0] width_reg = 13'd320;
	logic [12:0] height_reg = 13'd240;
	int          cols_done = 0;
	int          rows_done = 0;
	bit          header_out = 1'b0;

	bmp24_stream_from_rgb565_top #(
		.MAX_SIDE(SIDE_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.run_end(run_end),
		.frame_end(frame_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// zero maps to one, anything past the max side saturates
	function automatic int side_clamp(logic [12:0] v);
		if (v == 13'd0)
			return 1;
		if (int'(v) > SIDE_MAX)
			return SIDE_MAX;
		return int'(v);
	endfunction

	function automatic logic [12:0] pick_side(bit extreme);
		if (!extreme)
			return 13'($urandom_range(1, 9));
		case ($urandom_range(0, 4))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'(SIDE_MAX);
			3: return 13'h1FFF;
			default: return 13'($urandom_range(0, 8191));
		endcase
	endfunction

	// expected bytes of one accepted pixel: optional header, BGR, row padding
	task automatic predict_pixel_bytes(input logic [15:0] px);
		int          w;
		int          h;
		int          pad;
		bit          row_done;
		bit          frame_done;
		logic [31:0] row_bytes;
		logic [31:0] img_bytes;
		logic [31:0] file_bytes;
		logic [31:0] w32;
		logic [31:0] h32;
		logic [7:0]  hdr [0:53];
		logic [4:0]  r5;
		logic [5:0]  g6;
		logic [4:0]  b5;

		w = side_clamp(width_reg);
		h = side_clamp(height_reg);
		w32 = 32'(w);
		h32 = 32'(h);
		r5 = px[15:11];
		g6 = px[10:5];
		b5 = px[4:0];

		if (!header_out) begin
			row_bytes = (w32 * 32'd3 + 32'd3) & ~32'd3;
			img_bytes = row_bytes * h32;
			file_bytes = img_bytes + 32'(bmp24_pkg::HDR_BYTES);
			for (int i = 0; i < bmp24_pkg::HDR_BYTES; i++)
				hdr[i] = 8'h00;
			hdr[bmp24_pkg::OFS_MAGIC_B] = bmp24_pkg::MAGIC_B;
			hdr[bmp24_pkg::OFS_MAGIC_M] = bmp24_pkg::MAGIC_M;
			hdr[bmp24_pkg::OFS_DATA_OFS] = bmp24_pkg::DATA_OFS;
			hdr[bmp24_pkg::OFS_INFO_SZ] = bmp24_pkg::INFO_SZ;
			hdr[bmp24_pkg::OFS_PLANES] = bmp24_pkg::PLANES;
			hdr[bmp24_pkg::OFS_BPP] = bmp24_pkg::BPP;
			for (int k = 0; k < 4; k++) begin
				hdr[bmp24_pkg::OFS_FILE_SZ + k] = file_bytes[8*k +: 8];
				hdr[bmp24_pkg::OFS_WIDTH + k] = w32[8*k +: 8];
				hdr[bmp24_pkg::OFS_HEIGHT + k] = h32[8*k +: 8];
				hdr[bmp24_pkg::OFS_IMG_SZ + k] = img_bytes[8*k +: 8];
			end
			for (int i = 0; i < bmp24_pkg::HDR_BYTES; i++)
				bytes_due.push_back('{hdr[i], 1'b0, 1'b0});
			header_out = 1'b1;
		end

		// row and frame end use reach-or-pass against the current size
		row_done = (cols_done + 1 >= w);
		frame_done = row_done && (rows_done + 1 >= h);
		pad = row_done ? (w & 3) : 0;

		bytes_due.push_back('{{b5, b5[4:2]}, 1'b0, 1'b0});
		bytes_due.push_back('{{g6, g6[5:4]}, 1'b0, 1'b0});
		bytes_due.push_back('{{r5, r5[4:2]}, pad == 0, pad == 0 && frame_done});
		for (int i = 0; i < pad; i++)
			bytes_due.push_back('{8'h00, i == pad - 1, i == pad - 1 && frame_done});

		if (row_done) begin
			cols_done = 0;
			rows_done++;
			if (frame_done) begin
				rows_done = 0;
				header_out = 1'b0;
			end
		end else begin
			cols_done++;
		end
	endtask

	task automatic queue_pixel(input logic [15:0] px);
		pixels_pending.push_back(px);
		pixels_in_flight++;
	endtask

	// block idle: every pixel taken, every byte seen, then a short margin
	task automatic wait_drained();
		while (pixels_in_flight != 0 || bytes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// width then height on consecutive cycles; called only while idle
	task automatic set_frame_size(input logic [12:0] w_raw, input logic [12:0] h_raw);
		cfg_we <= 1'b1;
		cfg_index <= bmp24_pkg::REG_IMAGE_WIDTH;
		cfg_data <= w_raw;
		width_reg = w_raw;
		@(negedge clk);
		cfg_index <= bmp24_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= h_raw;
		height_reg = h_raw;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver: new pixel beat or idle at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (!in_valid || pixel_taken) begin
				pixel_taken = 1'b0;
				if (pixels_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					pixel <= pixels_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on pixel beats, check byte beats
	always @(posedge clk) begin
		bmp_byte_t got;
		bmp_byte_t want;

		if (arst_n && in_valid && in_ready && !pixel_taken) begin
			predict_pixel_bytes(pixel);
			pixel_taken = 1'b1;
			pixels_in_flight--;
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{out_byte, run_end, frame_end};
			if (bytes_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected byte %02h run_end %0b frame_end %0b",
						$realtime, out_byte, run_end, frame_end);
				mismatches++;
			end else begin
				want = bytes_due.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("%0t: byte exp %02h/%0b/%0b got %02h/%0b/%0b", $realtime,
							want.data, want.pixel_last, want.file_last,
							out_byte, run_end, frame_end);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [12:0] w_raw;
		logic [12:0] h_raw;
		int          wc;
		int          hc;
		int          remaining;
		int          n;
		int          left;
		bit          first;
		logic [15:0] px;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 17;
		recv_idle_pct = 60;
		@(negedge clk);

		// reset size 320x240: header from reset values, all-zero and all-one pixels
		queue_pixel(16'h0000);
		queue_pixel(16'hFFFF);
		wait_drained();

		// zero sizes act as one; shrinking mid-row ends row and frame at once
		set_frame_size(13'd0, 13'd0);
		queue_pixel(16'hF800);
		queue_pixel(16'h07E0);
		wait_drained();

		// oversized registers saturate in the header
		set_frame_size(13'h1FFF, 13'h1FFF);
		queue_pixel(16'h001F);
		queue_pixel(16'h8410);
		wait_drained();

		// width 3: three pad bytes; finish a 3x2 frame from mid-row
		set_frame_size(13'd3, 13'd2);
		queue_pixel(16'h0821);
		queue_pixel(16'h7BEF);
		queue_pixel(16'hAAAA);
		queue_pixel(16'h5555);
		queue_pixel(16'hFFFF);
		wait_drained();

		// width 2 (two pad bytes) and width 4 (none), single-row frames
		set_frame_size(13'd2, 13'd1);
		queue_pixel(16'h1234);
		queue_pixel(16'hFEDC);
		wait_drained();
		set_frame_size(13'd4, 13'd1);
		queue_pixel(16'h0001);
		queue_pixel(16'h8000);
		queue_pixel(16'h0020);
		queue_pixel(16'h0800);
		wait_drained();

		// random frames under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 60 : 0;
			recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 17 : 0;
			left = RANDOM_PER_MODE;
			first = 1'b1;
			while (left > 0) begin
				w_raw = pick_side($urandom_range(0, 9) == 0);
				h_raw = pick_side($urandom_range(0, 9) == 0);
				if (h_raw < 13'd10 && h_raw > 13'd3)
					h_raw = 13'($urandom_range(1, 3));
				set_frame_size(w_raw, h_raw);
				wc = side_clamp(w_raw);
				hc = side_clamp(h_raw);

				// pixels left to close the current frame
				remaining = (cols_done < wc) ? wc - cols_done : 1;
				if (rows_done + 1 < hc)
					remaining += (hc - rows_done - 1) * wc;
				if (remaining > 24)
					n = $urandom_range(1, 12);
				else if ($urandom_range(0, 4) == 0)
					n = $urandom_range(1, remaining + 3);
				else
					n = remaining;

				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0)
						px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					else
						px = 16'($urandom_range(0, 65535));
					queue_pixel(px);
					// hold the sender until the block has drained
					if (first && i == n / 2 - 1)
						wait_drained();
				end
				first = 1'b0;
				wait_drained();
				left -= n;
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
